// ----- hw/rtl/tct_pkg.sv -----
package tct_pkg;

    localparam int DEFAULT_MAX_CONTACTS = 8;
    // slot index width covers the largest supported table of 32 contacts
    localparam int SLOT_W = 5;

    localparam logic [2:0] REQ_TOUCH  = 3'd0;
    localparam logic [2:0] REQ_EOF    = 3'd1;
    localparam logic [2:0] REQ_CIRCLE = 3'd2;
    localparam logic [2:0] REQ_BOX    = 3'd3;
    localparam logic [2:0] REQ_QUERY  = 3'd4;

    localparam logic [1:0] PH_TRIGGER  = 2'd1;
    localparam logic [1:0] PH_HELD     = 2'd2;
    localparam logic [1:0] PH_RELEASED = 2'd3;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_UPD  = 2'd1,
        WR_NEW  = 2'd2,
        WR_EOF  = 2'd3
    } t_wr_op;

    // request walking down the cell row, with the partial results it collects
    typedef struct packed {
        logic              vld;
        logic [2:0]        req;
        logic [7:0]        id;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [1:0]        qph;
        logic [15:0]       spx;
        logic [15:0]       spy;
        logic [31:0]       r2;
        logic              cand1;   // previous slot matches the phase
        logic [15:0]       adx1;
        logic [15:0]       ady1;
        logic              cand2;   // slot two back matches the phase
        logic [31:0]       sqx2;
        logic [31:0]       sqy2;
        logic              hit;
        logic              found;
        logic [SLOT_W-1:0] mslot;
        logic [15:0]       mx;
        logic [15:0]       my;
        logic [1:0]        mph;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } t_pkt;

    typedef struct packed {
        t_wr_op            op;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        id;
        logic [15:0]       x;
        logic [15:0]       y;
    } t_wr;

endpackage

// ----- hw/rtl/tct_cell.sv -----
module tct_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tct_pkg::t_pkt i_pkt,
    input  tct_pkg::t_wr  i_wr,
    output tct_pkg::t_pkt o_pkt
);
    import tct_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(IDX);

    logic        r_valid;
    logic        r_seen;
    logic [7:0]  r_id;
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [1:0]  r_phase;
    t_pkt        r_pkt;
    t_pkt        n_pkt;

    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [15:0] w_adx;
    logic [15:0] w_ady;
    logic [32:0] w_d2;

    always_comb begin
        w_dx  = {r_x[15], r_x} - {i_pkt.px[15], i_pkt.px};
        w_dy  = {r_y[15], r_y} - {i_pkt.py[15], i_pkt.py};
        w_adx = w_dx[16] ? 16'(17'd0 - w_dx) : w_dx[15:0];
        w_ady = w_dy[16] ? 16'(17'd0 - w_dy) : w_dy[15:0];
        w_d2  = {1'b0, i_pkt.sqx2} + {1'b0, i_pkt.sqy2};

        n_pkt = i_pkt;
        // box test on the previous slot, circle test on the one before it
        if (i_pkt.cand1 && i_pkt.req == REQ_BOX
            && i_pkt.adx1 <= {1'b0, i_pkt.spx[15:1]}
            && i_pkt.ady1 <= {1'b0, i_pkt.spy[15:1]}) begin
            n_pkt.hit = 1'b1;
        end
        if (i_pkt.cand2 && i_pkt.req == REQ_CIRCLE && w_d2 <= {1'b0, i_pkt.r2}) begin
            n_pkt.hit = 1'b1;
        end
        n_pkt.cand2 = i_pkt.cand1;
        n_pkt.sqx2  = i_pkt.adx1 * i_pkt.adx1;
        n_pkt.sqy2  = i_pkt.ady1 * i_pkt.ady1;
        n_pkt.cand1 = r_valid && (r_phase == i_pkt.qph);
        n_pkt.adx1  = w_adx;
        n_pkt.ady1  = w_ady;

        if (r_valid && r_id == i_pkt.id && !i_pkt.found) begin
            n_pkt.found = 1'b1;
            n_pkt.mslot = SLOT;
            n_pkt.mx    = r_x;
            n_pkt.my    = r_y;
            n_pkt.mph   = r_phase;
        end
        if (!r_valid && !i_pkt.free_found) begin
            n_pkt.free_found = 1'b1;
            n_pkt.free_slot  = SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.vld <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            case (i_wr.op)
                WR_EOF: begin
                    if (r_valid && !r_seen) begin
                        if (r_phase == PH_RELEASED) begin
                            r_valid <= 1'b0;
                        end
                    end
                    r_seen <= 1'b0;
                end
                WR_UPD: begin
                    if (i_wr.slot == SLOT) begin
                        r_seen <= 1'b1;
                    end
                end
                WR_NEW: begin
                    if (i_wr.slot == SLOT) begin
                        r_valid <= 1'b1;
                        r_seen  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // slot payload, no reset: read only behind r_valid
    always_ff @(posedge i_clk) begin
        case (i_wr.op)
            WR_EOF: begin
                if (r_valid && !r_seen && r_phase != PH_RELEASED) begin
                    r_phase <= PH_RELEASED;
                end
            end
            WR_UPD: begin
                if (i_wr.slot == SLOT) begin
                    r_x     <= i_wr.x;
                    r_y     <= i_wr.y;
                    r_phase <= (r_phase == PH_RELEASED) ? PH_TRIGGER : PH_HELD;
                end
            end
            WR_NEW: begin
                if (i_wr.slot == SLOT) begin
                    r_id    <= i_wr.id;
                    r_x     <= i_wr.x;
                    r_y     <= i_wr.y;
                    r_phase <= PH_TRIGGER;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pkt = r_pkt;

endmodule

// ----- hw/rtl/touch_contact_tracker.sv -----
// Items are taken one at a time: a new input transfer is accepted only once the previous
// item has left the entry stage and the cell row. The request walks the cell row one slot
// per cycle, behind the entry stage and ahead of one tail stage.
// A result held at the output stalls only the following item, at the tail stage.
// Reset (i_rst_n low, synchronous) empties the table and all stages; slot payload
// is not reset.
module touch_contact_tracker #(
    parameter int MAX_CONTACTS = tct_pkg::DEFAULT_MAX_CONTACTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // touch_id[7:0], pos_x_in[23:8], pos_y_in[39:24], query_phase[41:40],
    // span_x[57:42], span_y[73:58], zero[79:74]
    input  logic [tct_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[2:0]
    input  logic [tct_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // hit[0], found[1], pos_x_out[17:2], pos_y_out[33:18], phase_out[35:34],
    // table_full[36], zero[39:37]
    output logic [tct_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import tct_pkg::*;

    t_pkt w_pkt [MAX_CONTACTS+1];
    t_pkt r_head;
    t_pkt n_head;
    t_pkt r_t1;
    t_pkt n_t1;
    t_wr  w_wr;

    logic                  w_accept;
    logic                  w_busy;
    logic                  w_t1_go;
    logic                  w_hit;
    logic [32:0]           w_d2;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] n_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_head            = r_head;
        n_head.vld        = w_accept;
        n_head.req        = i_s_axis_tuser[2:0];
        n_head.id         = i_s_axis_tdata[7:0];
        n_head.px         = i_s_axis_tdata[23:8];
        n_head.py         = i_s_axis_tdata[39:24];
        n_head.qph        = i_s_axis_tdata[41:40];
        n_head.spx        = i_s_axis_tdata[57:42];
        n_head.spy        = i_s_axis_tdata[73:58];
        n_head.cand1      = 1'b0;
        n_head.cand2      = 1'b0;
        n_head.hit        = 1'b0;
        n_head.found      = 1'b0;
        n_head.free_found = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else begin
            r_head <= n_head;
        end
    end

    always_comb begin
        w_pkt[0]    = r_head;
        w_pkt[0].r2 = r_head.spx * r_head.spx;
    end

    for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_cell
        tct_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pkt   (w_pkt[g]),
            .i_wr    (w_wr),
            .o_pkt   (w_pkt[g+1])
        );
    end

    always_comb begin
        w_busy = r_head.vld;
        for (int i = 1; i <= MAX_CONTACTS; i++) begin
            w_busy = w_busy | w_pkt[i].vld;
        end
    end

    assign w_t1_go         = r_t1.vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !w_busy && (!r_t1.vld || w_t1_go);

    // tail: finish the tests on the last two slots
    always_comb begin
        n_t1 = w_pkt[MAX_CONTACTS];
        w_d2 = {1'b0, n_t1.sqx2} + {1'b0, n_t1.sqy2};
        if (n_t1.cand1 && n_t1.req == REQ_BOX
            && n_t1.adx1 <= {1'b0, n_t1.spx[15:1]}
            && n_t1.ady1 <= {1'b0, n_t1.spy[15:1]}) begin
            n_t1.hit = 1'b1;
        end
        if (n_t1.cand2 && n_t1.req == REQ_CIRCLE && w_d2 <= {1'b0, n_t1.r2}) begin
            n_t1.hit = 1'b1;
        end
        n_t1.cand2 = n_t1.cand1;
        n_t1.sqx2  = n_t1.adx1 * n_t1.adx1;
        n_t1.sqy2  = n_t1.ady1 * n_t1.ady1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.vld <= 1'b0;
        end else if (!r_t1.vld || w_t1_go) begin
            r_t1 <= n_t1;
        end
    end

    assign w_hit = r_t1.hit
        || (r_t1.cand2 && r_t1.req == REQ_CIRCLE
            && ({1'b0, r_t1.sqx2} + {1'b0, r_t1.sqy2}) <= {1'b0, r_t1.r2});

    // commit table updates as the result leaves the tail
    always_comb begin
        w_wr.op   = WR_NONE;
        w_wr.slot = r_t1.mslot;
        w_wr.id   = r_t1.id;
        w_wr.x    = r_t1.px;
        w_wr.y    = r_t1.py;
        if (w_t1_go) begin
            if (r_t1.req == REQ_TOUCH) begin
                if (r_t1.found) begin
                    w_wr.op = WR_UPD;
                end else if (r_t1.free_found) begin
                    w_wr.op   = WR_NEW;
                    w_wr.slot = r_t1.free_slot;
                end
            end else if (r_t1.req == REQ_EOF) begin
                w_wr.op = WR_EOF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_t1_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_comb begin
        n_out    = '0;
        n_out[0] = (r_t1.req == REQ_CIRCLE || r_t1.req == REQ_BOX) && w_hit;
        if (r_t1.req == REQ_QUERY && r_t1.found) begin
            n_out[1]     = 1'b1;
            n_out[17:2]  = r_t1.mx;
            n_out[33:18] = r_t1.my;
            n_out[35:34] = r_t1.mph;
        end
        n_out[36] = (r_t1.req == REQ_TOUCH) && !r_t1.found && !r_t1.free_found;
    end

    always_ff @(posedge i_clk) begin
        if (w_t1_go) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

// ----- hw/rtl/tct_checker.sv -----
module tct_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [tct_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [tct_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tct_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: the entry stage is busy right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[1] |-> o_m_axis_tdata[35:2] == 34'd0)
        else $error("query fields set without found");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind touch_contact_tracker tct_checker u_tct_checker (.*);

// ----- tb/tct_checker.sv -----
module tct_scoreboard #(
    parameter int MAX_CONTACTS = tct_pkg::DEFAULT_MAX_CONTACTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // touch_id[7:0], pos_x_in[23:8], pos_y_in[39:24], query_phase[41:40],
    // span_x[57:42], span_y[73:58], zero[79:74]
    input  logic [tct_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type[2:0]
    input  logic [tct_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // hit[0], found[1], pos_x_out[17:2], pos_y_out[33:18], phase_out[35:34],
    // table_full[36], zero[39:37]
    input  logic [tct_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_hits,
    output int                             o_fulls
);
    import tct_pkg::*;

    // same bit order as the result tdata, lowest field last
    typedef struct packed {
        logic        full;
        logic [1:0]  ph;
        logic [15:0] y;
        logic [15:0] x;
        logic        found;
        logic        hit;
    } t_result;

    logic                slot_used [MAX_CONTACTS];
    logic [7:0]          slot_tag  [MAX_CONTACTS];
    logic signed [15:0]  slot_px   [MAX_CONTACTS];
    logic signed [15:0]  slot_py   [MAX_CONTACTS];
    logic [1:0]          slot_ph   [MAX_CONTACTS];
    logic                slot_seen [MAX_CONTACTS];

    t_result expected_q [$];

    int fails   = 0;
    int pending = 0;
    int checked = 0;
    int hits    = 0;
    int fulls   = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_hits       = hits;
    assign o_fulls      = fulls;

    function automatic int lookup_contact(input logic [7:0] id);
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (slot_used[i] && slot_tag[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_result track_request(
        input logic [2:0]         req,
        input logic [7:0]         id,
        input logic signed [15:0] px,
        input logic signed [15:0] py,
        input logic [1:0]         qph,
        input logic [15:0]        spx,
        input logic [15:0]        spy
    );
        t_result res;
        int      s;
        longint  dx;
        longint  dy;
        res = '0;
        case (req)
            REQ_TOUCH: begin
                s = lookup_contact(id);
                if (s >= 0) begin
                    slot_px[s]   = px;
                    slot_py[s]   = py;
                    slot_ph[s]   = (slot_ph[s] == PH_RELEASED) ? PH_TRIGGER : PH_HELD;
                    slot_seen[s] = 1'b1;
                end else begin
                    // take the lowest free slot
                    for (int i = 0; i < MAX_CONTACTS; i++) begin
                        if (s < 0 && !slot_used[i]) begin
                            s = i;
                        end
                    end
                    if (s >= 0) begin
                        slot_used[s] = 1'b1;
                        slot_tag[s]  = id;
                        slot_px[s]   = px;
                        slot_py[s]   = py;
                        slot_ph[s]   = PH_TRIGGER;
                        slot_seen[s] = 1'b1;
                    end else begin
                        res.full = 1'b1;
                    end
                end
            end
            REQ_EOF: begin
                for (int i = 0; i < MAX_CONTACTS; i++) begin
                    if (slot_used[i] && !slot_seen[i]) begin
                        if (slot_ph[i] == PH_RELEASED) begin
                            slot_used[i] = 1'b0;
                        end else begin
                            slot_ph[i] = PH_RELEASED;
                        end
                    end
                    slot_seen[i] = 1'b0;
                end
            end
            REQ_CIRCLE, REQ_BOX: begin
                for (int i = 0; i < MAX_CONTACTS; i++) begin
                    if (!res.hit && slot_used[i] && slot_ph[i] == qph) begin
                        dx = longint'(slot_px[i]) - longint'(px);
                        dy = longint'(slot_py[i]) - longint'(py);
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (req == REQ_CIRCLE) begin
                            res.hit = (dx * dx + dy * dy <= longint'(spx) * longint'(spx));
                        end else begin
                            res.hit = (dx <= longint'(spx >> 1)) && (dy <= longint'(spy >> 1));
                        end
                    end
                end
            end
            REQ_QUERY: begin
                s = lookup_contact(id);
                if (s >= 0) begin
                    res.found = 1'b1;
                    res.x     = slot_px[s];
                    res.y     = slot_py[s];
                    res.ph    = slot_ph[s];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        fails++;
        if (fails <= 30) begin
            $display("tct_scoreboard: result %0d, %s: got %0h, expected %0h",
                     checked, what, got_v, want_v);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        checked++;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no request waiting", got[31:0], '0);
            return;
        end
        want = expected_q.pop_front();
        hits  += want.hit;
        fulls += want.full;
        if (got.hit !== want.hit)     report_mismatch("hit", got.hit, want.hit);
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.x !== want.x)         report_mismatch("pos_x_out", got.x, want.x);
        if (got.y !== want.y)         report_mismatch("pos_y_out", got.y, want.y);
        if (got.ph !== want.ph)       report_mismatch("phase_out", got.ph, want.ph);
        if (got.full !== want.full)   report_mismatch("table_full", got.full, want.full);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CONTACTS; i++) begin
                slot_used[i] = 1'b0;
                slot_seen[i] = 1'b0;
                slot_ph[i]   = '0;
            end
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result(t_result'(i_m_tdata[36:0]));
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(track_request(i_s_tuser, i_s_tdata[7:0],
                    i_s_tdata[23:8], i_s_tdata[39:24], i_s_tdata[41:40],
                    i_s_tdata[57:42], i_s_tdata[73:58]));
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import tct_pkg::*;

    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam logic [1:0] PH_NONE          = 2'd0;
    localparam int ITEM_TARGET = 1300;
    localparam int POOL_SIZE   = 12;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 800;
    localparam int CYCLE_LIMIT = 600000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_results;
    int checked_count;
    int hit_count;
    int full_count;

    int items_counted = 0;
    int req_count [8];
    int send_burst    = 0;
    int cycle_count   = 0;
    int pool [POOL_SIZE];
    logic [15:0] last_x [256];
    logic [15:0] last_y [256];

    touch_contact_tracker DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tct_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_count),
        .o_hits       (hit_count),
        .o_fulls      (full_count)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[touch_contact_tracker] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_span();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2, 3, 4, 5, 6: return 16'($urandom_range(0, 100));
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random back-pressure, plus one long hold-off once traffic is going
    initial begin
        int idle_left;
        int burst_left;
        bit held;
        idle_left  = 0;
        burst_left = 0;
        held       = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && items_counted >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else begin
                m_tready <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    idle_left = pick_gap();
                    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic send_request(input logic [2:0] req, input logic [7:0] id,
                                input logic [15:0] x, input logic [15:0] y,
                                input logic [1:0] qph, input logic [15:0] spx,
                                input logic [15:0] spy);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, spy, spx, qph, y, x, id};
        do @(posedge clk); while (s_tready !== 1'b1);
        req_count[req]++;
        if (req <= REQ_QUERY) items_counted++;
        if (req == REQ_TOUCH) begin
            last_x[id] = x;
            last_y[id] = y;
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic issue(input logic [2:0] req, input logic [7:0] id,
                         input logic [15:0] x, input logic [15:0] y,
                         input logic [1:0] qph, input logic [15:0] spx,
                         input logic [15:0] spy);
        send_request(req, id, x, y, qph, spx, spy);
        if (send_burst > 0) begin
            send_burst--;
        end else begin
            idle_cycles(pick_gap());
            if ($urandom_range(0, 19) == 0) send_burst = $urandom_range(10, 40);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
    endtask

    task automatic send_random_query();
        logic [7:0]  aim;
        logic [2:0]  req;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [1:0]  qph;
        aim = 8'(pool[$urandom_range(0, POOL_SIZE - 1)]);
        case ($urandom_range(0, 2))
            0: req = REQ_QUERY;
            1: req = REQ_CIRCLE;
            default: req = REQ_BOX;
        endcase
        qph = ($urandom_range(0, 7) == 0) ? PH_NONE : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 4) == 0) begin
            cx = rand_coord();
            cy = rand_coord();
        end else begin
            // aim near a recent report so hit tests land on both sides of the edge
            cx = last_x[aim] + 16'($urandom_range(0, 80)) - 16'd40;
            cy = last_y[aim] + 16'($urandom_range(0, 80)) - 16'd40;
        end
        if (req == REQ_QUERY && $urandom_range(0, 5) == 0) aim = 8'($urandom);
        issue(req, aim, cx, cy, qph, rand_span(), rand_span());
    endtask

    task automatic send_random_report();
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        id = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                          : 8'(pool[$urandom_range(0, POOL_SIZE - 1)]);
        if ($urandom_range(0, 3) == 0) begin
            x = rand_coord();
            y = rand_coord();
        end else begin
            x = last_x[id] + 16'($urandom_range(0, 16)) - 16'd8;
            y = last_y[id] + 16'($urandom_range(0, 16)) - 16'd8;
        end
        issue(REQ_TOUCH, id, x, y, 2'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int  n_reports;
        int  n_unused;
        bit  hold_burst_set;
        bit  drained_mid;
        hold_burst_set = 1'b0;
        drained_mid    = 1'b0;
        for (int i = 0; i < 8; i++) req_count[i] = 0;
        for (int i = 0; i < 256; i++) begin
            last_x[i] = '0;
            last_y[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom_range(0, 255);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // corners, repeat report, circle edge at distance five
        issue(REQ_TOUCH, 8'd0, 16'h8000, 16'h8000, PH_NONE, 16'h0, 16'h0);
        issue(REQ_TOUCH, 8'd255, 16'h7fff, 16'h7fff, PH_RELEASED, 16'hffff, 16'hffff);
        issue(REQ_QUERY, 8'd0, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_QUERY, 8'd17, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_TOUCH, 8'd0, 16'd100, -16'sd200, PH_NONE, 16'h0, 16'h0);
        issue(REQ_CIRCLE, 8'd0, 16'd103, -16'sd196, PH_HELD, 16'd5, 16'h0);
        issue(REQ_CIRCLE, 8'd0, 16'd103, -16'sd196, PH_HELD, 16'd4, 16'h0);
        // box edge with odd spans, then one half span too short
        issue(REQ_BOX, 8'd0, 16'd32764, 16'd32765, PH_TRIGGER, 16'd7, 16'd5);
        issue(REQ_BOX, 8'd0, 16'd32764, 16'd32765, PH_TRIGGER, 16'd5, 16'd5);
        issue(REQ_CIRCLE, 8'd0, 16'h0, 16'h0, PH_NONE, 16'hffff, 16'hffff);
        issue(REQ_CIRCLE, 8'd0, 16'h7fff, 16'h7fff, PH_TRIGGER, 16'h0, 16'h0);
        issue(REQ_CIRCLE, 8'd0, 16'h8000, 16'h8000, PH_TRIGGER, 16'hffff, 16'h0);
        for (int r = REQ_UNUSED_FIRST; r <= REQ_UNUSED_LAST; r++) begin
            issue(3'(r), 8'hff, 16'hffff, 16'hffff, 2'd3, 16'hffff, 16'hffff);
        end
        // fill the table, then overflow it
        for (int i = 1; i <= 6; i++) begin
            issue(REQ_TOUCH, 8'(i), rand_coord(), rand_coord(), PH_NONE, 16'h0, 16'h0);
        end
        issue(REQ_TOUCH, 8'd200, 16'd1, 16'd1, PH_NONE, 16'h0, 16'h0);
        // release, re-trigger from released, free, reuse lowest slot
        issue(REQ_EOF, 8'd0, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_TOUCH, 8'd0, 16'd50, 16'd60, PH_NONE, 16'h0, 16'h0);
        issue(REQ_EOF, 8'd0, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_QUERY, 8'd255, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_TOUCH, 8'd255, 16'd7, 16'd9, PH_NONE, 16'h0, 16'h0);
        issue(REQ_EOF, 8'd0, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
        issue(REQ_TOUCH, 8'd200, 16'd1, 16'd1, PH_NONE, 16'h0, 16'h0);
        wait_drained();

        while (items_counted < ITEM_TARGET) begin
            n_reports = $urandom_range(0, 9);
            for (int k = 0; k < n_reports; k++) begin
                send_random_report();
                if ($urandom_range(0, 2) == 0) send_random_query();
            end
            if ($urandom_range(0, 19) == 0) begin
                issue(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), 8'($urandom),
                      16'($urandom), 16'($urandom), 2'($urandom), 16'($urandom),
                      16'($urandom));
            end
            // skip a frame end now and then, or send two in a row
            if ($urandom_range(0, 29) != 0) begin
                issue(REQ_EOF, 8'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                      16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 24) == 0) begin
                issue(REQ_EOF, 8'd0, 16'h0, 16'h0, PH_NONE, 16'h0, 16'h0);
            end
            if ($urandom_range(0, 3) == 0) send_random_query();
            // keep offering back to back while the receiver holds off
            if (!hold_burst_set && items_counted >= HOLD_AT) begin
                hold_burst_set = 1'b1;
                send_burst     = 80;
            end
            if ((!drained_mid && items_counted >= DRAIN_AT) || $urandom_range(0, 49) == 0) begin
                drained_mid = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (30) @(negedge clk);

        n_unused = 0;
        for (int r = REQ_UNUSED_FIRST; r <= REQ_UNUSED_LAST; r++) begin
            n_unused += req_count[r];
        end
        $display("summary: %0d reports, %0d frame ends, %0d circle, %0d box, %0d lookups",
                 req_count[REQ_TOUCH], req_count[REQ_EOF], req_count[REQ_CIRCLE],
                 req_count[REQ_BOX], req_count[REQ_QUERY]);
        $display("summary: %0d unused, %0d checked, %0d hits, %0d full drops, %0d mismatches",
                 n_unused, checked_count, hit_count, full_count, fail_count);
        if (fail_count == 0) begin
            $display("[touch_contact_tracker] OK");
        end else begin
            $display("[touch_contact_tracker] ERROR");
        end
        $finish;
    end

endmodule
